>>> sv/aselu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aselu_pkg
// Shared types, constants and arithmetic helpers of the affine shifted ELU.
// ----------------------------------------------------------------------------
package aselu_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int ACC_WIDTH      = 48;
    localparam int EXP_TABLE_BITS = 6;

    localparam int Q_W       = 32;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_A_W   = ACC_WIDTH;
    localparam int MUL_B_W   = 32;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int TAB_W     = 31;
    localparam int EXP_IDX_W = EXP_TABLE_BITS + 1;
    localparam int EXP_COUNT = (1 << EXP_TABLE_BITS) + 1;
    localparam int ILP_W     = 30 - EXP_TABLE_BITS;
    localparam int M_W       = FRAC_BITS + 7;
    localparam int N_W       = 7;
    localparam int SH_W      = 8;

    localparam logic signed [Q_W-1:0] ONE_Q     = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [Q_W-1:0] LOG2E_Q30 = 32'sd1549082005;
    localparam longint unsigned       LN2_Q30   = 64'd744261118;
    localparam logic [M_W-1:0]        M_LIMIT   = M_W'(64) << FRAC_BITS;
    localparam logic [63:0]           PROD_CAP  = 64'd1 << 61;

    localparam logic signed [64:0] ACC_MAX = (65'sd1 <<< (ACC_WIDTH - 1)) - 65'sd1;
    localparam logic signed [64:0] ACC_MIN = -ACC_MAX - 65'sd1;

    typedef struct packed {
        logic                  req_type;
        logic signed [Q_W-1:0] x_value;
        logic signed [Q_W-1:0] out_grad;
        logic                  last_item;
    } in_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] result_value;
        logic signed [Q_W-1:0] grad_a;
        logic signed [Q_W-1:0] grad_b;
        logic                  grads_valid;
    } out_item_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_A   = 3'd0,
        REG_OFFSET_B  = 3'd1,
        REG_ALPHA     = 3'd2,
        REG_INV_ALPHA = 3'd3,
        REG_INV_SCALE = 3'd4,
        REG_LAMBDA    = 3'd5,
        REG_KL_WEIGHT = 3'd6,
        REG_OUT_WEIGHT = 3'd7
    } cfg_idx_t;

    // One code per product taken on the shared multiplier
    typedef enum logic [3:0] {
        OP_T   = 4'd0,   // a*x
        OP_U   = 4'd1,   // t*inv_alpha
        OP_V   = 4'd2,   // m*log2(e)
        OP_I   = 4'd3,   // table interpolation
        OP_F   = 4'd4,   // alpha*e
        OP_D   = 4'd5,   // a*e
        OP_G   = 4'd6,   // out_grad*delta
        OP_LX  = 4'd7,   // lambda*x
        OP_XE  = 4'd8,   // x*e
        OP_XI  = 4'd9,   // x*inv_alpha
        OP_LXE = 4'd10,  // lambda*xe
        OP_LE  = 4'd11,  // lambda*e
        OP_KA  = 4'd12,
        OP_OA  = 4'd13,
        OP_KB  = 4'd14,
        OP_OB  = 4'd15
    } op_t;

    typedef struct packed {
        op_t  op;
        logic mul_start;
        logic commit;
        logic load_item;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic t_neg_now;
        logic t_neg;
        logic bwd;
        logic last;
        logic out_free;
    } dp_status_t;

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [64:0] v);
        if (v > 65'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -65'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[Q_W-1:0];
        end
    endfunction

    function automatic logic signed [ACC_WIDTH-1:0] acc_add(
        input logic signed [ACC_WIDTH-1:0] acc,
        input logic signed [63:0]          d
    );
        logic signed [64:0] sum;
        sum = 65'(acc) + 65'(d);
        if (sum > ACC_MAX) begin
            return ACC_MAX[ACC_WIDTH-1:0];
        end else if (sum < ACC_MIN) begin
            return ACC_MIN[ACC_WIDTH-1:0];
        end else begin
            return sum[ACC_WIDTH-1:0];
        end
    endfunction

    // Shift-subtract quotient by a small term index, used only for the table build
    function automatic longint unsigned div_small(
        input longint unsigned num,
        input int unsigned     den
    );
        longint unsigned quo;
        longint unsigned rmd;
        quo = '0;
        rmd = '0;
        for (int b = 63; b >= 0; b--) begin
            rmd = {rmd[62:0], num[b]};
            if (rmd >= 64'(den)) begin
                rmd    = rmd - 64'(den);
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-i*ln2/N) in Q30 from a truncated Taylor series, built at elaboration
    function automatic logic [EXP_COUNT*TAB_W-1:0] build_exp_tab();
        logic [EXP_COUNT*TAB_W-1:0] tab;
        longint unsigned y;
        longint unsigned term;
        longint          sum;
        tab = '0;
        for (int i = 0; i < EXP_COUNT; i++) begin
            y    = (longint'(i) * LN2_Q30) >> EXP_TABLE_BITS;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int k = 1; k <= 24; k++) begin
                term = div_small((term * y) >> 30, k);
                if (k[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            tab[i*TAB_W +: TAB_W] = (sum < 0) ? '0 : TAB_W'(sum);
        end
        return tab;
    endfunction

    localparam logic [EXP_COUNT*TAB_W-1:0] EXP_TAB = build_exp_tab();

    function automatic logic [TAB_W-1:0] exp_lookup(input logic [EXP_IDX_W-1:0] idx);
        return EXP_TAB[idx*TAB_W +: TAB_W];
    endfunction

endpackage
`default_nettype wire

>>> sv/aselu_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aselu_mul
// Shared fixed point multiplier: two partial products (low 32 and high 16 bits of a by b), sum, cap, sign.
// ----------------------------------------------------------------------------
module aselu_mul import aselu_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic signed [MUL_A_W-1:0] op_a,
    input  wire logic signed [MUL_B_W-1:0] op_b,
    output logic                           done,
    output logic [PROD_W-1:0]              prod,
    output logic signed [63:0]             res
);

    logic [4:0]               vld_reg;
    logic [MUL_A_W-1:0]       ma_reg;
    logic [MUL_B_W-1:0]       mb_reg;
    logic                     neg_reg;
    logic [63:0]              lo_reg;
    logic [MUL_A_W-1:0]       hi_reg;
    logic [PROD_W-1:0]        p_reg;
    logic signed [63:0]       res_reg;

    logic [PROD_W-FRAC_BITS-1:0] q_full;
    logic [63:0]                 q_cap;
    logic                        rem;
    logic signed [63:0]          res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], start};
        end
    end

    always_comb begin
        q_full   = p_reg[PROD_W-1:FRAC_BITS];
        q_cap    = (q_full > PROD_W'(PROD_CAP)) ? PROD_CAP : 64'(q_full);
        rem      = |p_reg[FRAC_BITS-1:0];
        res_next = neg_reg ? $signed(-q_cap - 64'(rem)) : $signed(q_cap);
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ma_reg  <= op_a[MUL_A_W-1] ? MUL_A_W'(-op_a) : MUL_A_W'(op_a);
            mb_reg  <= op_b[MUL_B_W-1] ? MUL_B_W'(-op_b) : MUL_B_W'(op_b);
            neg_reg <= op_a[MUL_A_W-1] ^ op_b[MUL_B_W-1];
        end
        if (vld_reg[0]) begin
            lo_reg <= 64'(ma_reg[31:0]) * 64'(mb_reg);
        end
        if (vld_reg[1]) begin
            hi_reg <= MUL_A_W'(MUL_A_W'(ma_reg[MUL_A_W-1:32]) * MUL_A_W'(mb_reg));
        end
        if (vld_reg[2]) begin
            p_reg <= (PROD_W'(hi_reg) << 32) + PROD_W'(lo_reg);
        end
        if (vld_reg[3]) begin
            res_reg <= res_next;
        end
    end

    assign done = vld_reg[4];
    assign prod = p_reg;
    assign res  = res_reg;

endmodule
`default_nettype wire

>>> sv/aselu_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aselu_dp
// Datapath: configuration, item and work registers, accumulators, result.
// ----------------------------------------------------------------------------
module aselu_dp import aselu_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire in_item_t             s_data,
    input  wire ctrl_cmd_t            cmd,
    output dp_status_t                status,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output out_item_t                 m_data
);

    logic signed [Q_W-1:0] scale_a_reg, offset_b_reg, inv_scale_reg;
    logic signed [Q_W-1:0] lambda_reg, kl_weight_reg, out_weight_reg;
    logic [30:0]           alpha_reg, inv_alpha_reg;

    logic signed [ACC_WIDTH-1:0] kl_a_reg, kl_b_reg, out_a_reg, out_b_reg;
    logic signed [ACC_WIDTH-1:0] kl_a_next, kl_b_next, out_a_next, out_b_next;

    in_item_t              item_reg;
    logic signed [Q_W-1:0] t_reg, t_next;
    logic [M_W-1:0]        m_reg, m_next;
    logic [N_W-1:0]        n_reg, n_next;
    logic [ILP_W-1:0]      frac_reg, frac_next;
    logic [TAB_W-1:0]      t0_reg, t0_next, d_reg, d_next;
    logic [FRAC_BITS:0]    e_reg, e_next;
    logic signed [Q_W-1:0] delta_reg, delta_next, res_reg, res_next;
    logic signed [Q_W-1:0] xe_reg, xe_next, s_reg, s_next;
    logic signed [Q_W-1:0] ga_reg, ga_next, gb_reg, gb_next;
    logic signed [63:0]    tmp_reg, tmp_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      mul_done;
    logic [PROD_W-1:0]         mul_p;
    logic signed [63:0]        mul_res;

    logic signed [Q_W-1:0] t_sum, t_plus, mul_sat;
    logic signed [63:0]    u_mag;
    logic [M_W-1:0]        m_new, v_val;
    logic [29:0]           r30;
    logic [EXP_IDX_W-1:0]  idx;
    logic [TAB_W-1:0]      t0_new, t1_new, p_int;
    logic [SH_W-1:0]       sh;
    logic                  fin_grads;

    aselu_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_p),
        .res     (mul_res)
    );

    // Operand select
    always_comb begin
        unique case (cmd.op)
            OP_T:   begin mul_a = MUL_A_W'(scale_a_reg);       mul_b = item_reg.x_value; end
            OP_U:   begin mul_a = MUL_A_W'(t_reg);             mul_b = 32'(inv_alpha_reg); end
            OP_V:   begin mul_a = MUL_A_W'(m_reg);             mul_b = LOG2E_Q30; end
            OP_I:   begin mul_a = MUL_A_W'(d_reg);             mul_b = 32'(frac_reg); end
            OP_F:   begin mul_a = MUL_A_W'(alpha_reg);         mul_b = 32'(e_reg); end
            OP_D:   begin mul_a = MUL_A_W'(scale_a_reg);       mul_b = 32'(e_reg); end
            OP_G:   begin mul_a = MUL_A_W'(item_reg.out_grad); mul_b = delta_reg; end
            OP_LX:  begin mul_a = MUL_A_W'(lambda_reg);        mul_b = item_reg.x_value; end
            OP_XE:  begin mul_a = MUL_A_W'(item_reg.x_value);  mul_b = 32'(e_reg); end
            OP_XI:  begin mul_a = MUL_A_W'(item_reg.x_value);  mul_b = 32'(inv_alpha_reg); end
            OP_LXE: begin mul_a = MUL_A_W'(lambda_reg);        mul_b = xe_reg; end
            OP_LE:  begin mul_a = MUL_A_W'(lambda_reg);        mul_b = 32'(e_reg); end
            OP_KA:  begin mul_a = kl_a_reg;                    mul_b = kl_weight_reg; end
            OP_OA:  begin mul_a = out_a_reg;                   mul_b = out_weight_reg; end
            OP_KB:  begin mul_a = kl_b_reg;                    mul_b = kl_weight_reg; end
            OP_OB:  begin mul_a = out_b_reg;                   mul_b = out_weight_reg; end
            default: begin mul_a = '0;                         mul_b = '0; end
        endcase
    end

    // Per-product terms
    always_comb begin
        t_sum   = sat32(65'(mul_res) + 65'(offset_b_reg));
        t_plus  = sat32(65'(t_sum) + 65'(alpha_reg));
        mul_sat = sat32(65'(mul_res));
        u_mag   = -mul_res;
        if (!mul_res[63]) begin
            m_new = '0;
        end else if (u_mag > 64'(M_LIMIT)) begin
            m_new = M_LIMIT;
        end else begin
            m_new = M_W'(u_mag);
        end
        v_val  = M_W'(mul_p >> 30);
        r30    = 30'(v_val[FRAC_BITS-1:0]) << (30 - FRAC_BITS);
        idx    = EXP_IDX_W'(r30[29 -: EXP_TABLE_BITS]);
        t0_new = exp_lookup(idx);
        t1_new = exp_lookup(idx + EXP_IDX_W'(1));
        p_int  = t0_reg - TAB_W'(mul_p >> ILP_W);
        sh     = SH_W'(30 - FRAC_BITS) + SH_W'(n_reg);
    end

    // Commit results of the finished product
    always_comb begin
        t_next     = t_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        frac_next  = frac_reg;
        t0_next    = t0_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        delta_next = delta_reg;
        res_next   = res_reg;
        xe_next    = xe_reg;
        s_next     = s_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        tmp_next   = tmp_reg;
        kl_a_next  = kl_a_reg;
        kl_b_next  = kl_b_reg;
        out_a_next = out_a_reg;
        out_b_next = out_b_reg;
        if (cmd.commit) begin
            unique case (cmd.op)
                OP_T: begin
                    t_next     = t_sum;
                    res_next   = t_plus;
                    delta_next = scale_a_reg;
                    e_next     = (FRAC_BITS+1)'(ONE_Q);
                end
                OP_U: m_next = m_new;
                OP_V: begin
                    n_next    = v_val[M_W-1:FRAC_BITS];
                    frac_next = r30[ILP_W-1:0];
                    t0_next   = t0_new;
                    d_next    = (t0_new > t1_new) ? t0_new - t1_new : '0;
                end
                OP_I:  e_next     = (FRAC_BITS+1)'(p_int >> sh);
                OP_F:  res_next   = mul_sat;
                OP_D:  delta_next = mul_sat;
                OP_G:  res_next   = mul_sat;
                OP_LX: begin
                    kl_a_next  = acc_add(kl_a_reg, mul_res - 64'(inv_scale_reg));
                    kl_b_next  = acc_add(kl_b_reg, 64'(lambda_reg));
                    out_a_next = acc_add(out_a_reg, 64'(item_reg.x_value));
                    out_b_next = acc_add(out_b_reg, 64'(ONE_Q));
                end
                OP_XE: xe_next  = mul_res[Q_W-1:0];
                OP_XI: tmp_next = -64'(inv_scale_reg) - mul_res;
                OP_LXE: begin
                    kl_a_next  = acc_add(kl_a_reg, tmp_reg + mul_res);
                    out_a_next = acc_add(out_a_reg, 64'(xe_reg));
                end
                OP_LE: begin
                    kl_b_next  = acc_add(kl_b_reg, $signed(mul_res - 64'(inv_alpha_reg)));
                    out_b_next = acc_add(out_b_reg, 64'(e_reg));
                end
                OP_KA: s_next  = mul_sat;
                OP_OA: ga_next = sat32(65'(s_reg) + 65'(mul_sat));
                OP_KB: s_next  = mul_sat;
                OP_OB: gb_next = sat32(65'(s_reg) + 65'(mul_sat));
                default: t_next = t_reg;
            endcase
        end
        // Drop the sums once the pass result leaves
        if (cmd.load_out && fin_grads) begin
            kl_a_next  = '0;
            kl_b_next  = '0;
            out_a_next = '0;
            out_b_next = '0;
        end
    end

    assign fin_grads    = item_reg.req_type & item_reg.last_item;
    assign m_valid_next = cmd.load_out | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_a_reg    <= ONE_Q;
            offset_b_reg   <= '0;
            alpha_reg      <= 31'(ONE_Q >>> 1);
            inv_alpha_reg  <= 31'(ONE_Q <<< 1);
            inv_scale_reg  <= ONE_Q;
            lambda_reg     <= ONE_Q;
            kl_weight_reg  <= '0;
            out_weight_reg <= '0;
            kl_a_reg       <= '0;
            kl_b_reg       <= '0;
            out_a_reg      <= '0;
            out_b_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_index))
                    REG_SCALE_A:    scale_a_reg    <= cfg_data;
                    REG_OFFSET_B:   offset_b_reg   <= cfg_data;
                    REG_ALPHA:      alpha_reg      <= cfg_data[30:0];
                    REG_INV_ALPHA:  inv_alpha_reg  <= cfg_data[30:0];
                    REG_INV_SCALE:  inv_scale_reg  <= cfg_data;
                    REG_LAMBDA:     lambda_reg     <= cfg_data;
                    REG_KL_WEIGHT:  kl_weight_reg  <= cfg_data;
                    REG_OUT_WEIGHT: out_weight_reg <= cfg_data;
                    default:        scale_a_reg    <= scale_a_reg;
                endcase
            end
            kl_a_reg    <= kl_a_next;
            kl_b_reg    <= kl_b_next;
            out_a_reg   <= out_a_next;
            out_b_reg   <= out_b_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        t_reg     <= t_next;
        m_reg     <= m_next;
        n_reg     <= n_next;
        frac_reg  <= frac_next;
        t0_reg    <= t0_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
        delta_reg <= delta_next;
        res_reg   <= res_next;
        xe_reg    <= xe_next;
        s_reg     <= s_next;
        ga_reg    <= ga_next;
        gb_reg    <= gb_next;
        tmp_reg   <= tmp_next;
        if (cmd.load_out) begin
            m_data_reg.result_value <= res_reg;
            m_data_reg.grad_a       <= fin_grads ? ga_reg : '0;
            m_data_reg.grad_b       <= fin_grads ? gb_reg : '0;
            m_data_reg.grads_valid  <= fin_grads;
        end
    end

    always_comb begin
        status.mul_done  = mul_done;
        status.t_neg_now = t_sum[Q_W-1];
        status.t_neg     = t_reg[Q_W-1];
        status.bwd       = item_reg.req_type;
        status.last      = item_reg.last_item;
        status.out_free  = ~m_valid_reg | m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

>>> sv/aselu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aselu_ctrl
// Controller: steps one item through its chain of products on the multiplier.
// ----------------------------------------------------------------------------
module aselu_ctrl import aselu_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [17:0] {
        ST_IDLE = 18'b000000000000000001,
        ST_T    = 18'b000000000000000010,
        ST_U    = 18'b000000000000000100,
        ST_V    = 18'b000000000000001000,
        ST_I    = 18'b000000000000010000,
        ST_F    = 18'b000000000000100000,
        ST_D    = 18'b000000000001000000,
        ST_G    = 18'b000000000010000000,
        ST_LX   = 18'b000000000100000000,
        ST_XE   = 18'b000000001000000000,
        ST_XI   = 18'b000000010000000000,
        ST_LXE  = 18'b000000100000000000,
        ST_LE   = 18'b000001000000000000,
        ST_KA   = 18'b000010000000000000,
        ST_OA   = 18'b000100000000000000,
        ST_KB   = 18'b001000000000000000,
        ST_OB   = 18'b010000000000000000,
        ST_OUT  = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;
    logic   mul_state;
    logic   done;
    state_t after_acc;

    assign done      = status.mul_done;
    assign after_acc = status.last ? ST_KA : ST_OUT;

    always_comb begin
        state_next = state_reg;
        mul_state  = 1'b1;
        cmd        = '0;
        cmd.op     = OP_T;
        unique case (state_reg)
            ST_IDLE: begin
                mul_state     = 1'b0;
                cmd.load_item = s_valid;
                if (s_valid) begin
                    state_next = ST_T;
                end
            end
            ST_T: begin
                cmd.op = OP_T;
                if (done) begin
                    if (status.t_neg_now) begin
                        state_next = ST_U;
                    end else begin
                        state_next = status.bwd ? ST_G : ST_OUT;
                    end
                end
            end
            ST_U: begin
                cmd.op = OP_U;
                if (done) state_next = ST_V;
            end
            ST_V: begin
                cmd.op = OP_V;
                if (done) state_next = ST_I;
            end
            ST_I: begin
                cmd.op = OP_I;
                if (done) state_next = status.bwd ? ST_D : ST_F;
            end
            ST_F: begin
                cmd.op = OP_F;
                if (done) state_next = ST_OUT;
            end
            ST_D: begin
                cmd.op = OP_D;
                if (done) state_next = ST_G;
            end
            ST_G: begin
                cmd.op = OP_G;
                if (done) state_next = status.t_neg ? ST_XE : ST_LX;
            end
            ST_LX: begin
                cmd.op = OP_LX;
                if (done) state_next = after_acc;
            end
            ST_XE: begin
                cmd.op = OP_XE;
                if (done) state_next = ST_XI;
            end
            ST_XI: begin
                cmd.op = OP_XI;
                if (done) state_next = ST_LXE;
            end
            ST_LXE: begin
                cmd.op = OP_LXE;
                if (done) state_next = ST_LE;
            end
            ST_LE: begin
                cmd.op = OP_LE;
                if (done) state_next = after_acc;
            end
            ST_KA: begin
                cmd.op = OP_KA;
                if (done) state_next = ST_OA;
            end
            ST_OA: begin
                cmd.op = OP_OA;
                if (done) state_next = ST_KB;
            end
            ST_KB: begin
                cmd.op = OP_KB;
                if (done) state_next = ST_OB;
            end
            ST_OB: begin
                cmd.op = OP_OB;
                if (done) state_next = ST_OUT;
            end
            ST_OUT: begin
                mul_state    = 1'b0;
                cmd.load_out = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                mul_state  = 1'b0;
                state_next = ST_IDLE;
            end
        endcase
        // Launch once per product, commit on its done pulse
        cmd.mul_start = mul_state & ~issued_reg;
        cmd.commit    = mul_state & done;
        issued_next   = mul_state & ~done;
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/affine_shifted_elu_fwd_bwd.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_shifted_elu_fwd_bwd
// Affine shifted ELU, forward and backward, with gradients of scale and offset.
// ----------------------------------------------------------------------------
// One item is in work at a time. Every product runs on a single shared
// multiplier (operand register, low and high partial products, sum, then cap
// and sign), started only after the last product is done. An item takes from
// 1 product (forward, t >= 0) up to 14 (last backward item with t < 0). A
// finished result sits in the output register while the next item is taken.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data.
// ----------------------------------------------------------------------------
module affine_shifted_elu_fwd_bwd import aselu_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    aselu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    aselu_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire
